@@ sv/sparse_rle_memory_image_decoder_unit_defines.svh @@
// Assertion macros for the decoder RTL, used by srle_parse.
// Both expect clk and arst_n to be visible where they are used.
`ifndef SPARSE_RLE_MEMORY_IMAGE_DECODER_UNIT_DEFINES_SVH
`define SPARSE_RLE_MEMORY_IMAGE_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SRLE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srle assertion failed");
`define SRLE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srle assertion failed");
`else
`define SRLE_ASSERT_SAME(lbl, ante, cons)
`define SRLE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/srle_pkg.sv @@
package srle_pkg;

	localparam int ADDR_W  = 16;
	localparam int WORD_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 8;

	localparam logic [BYTE_W-1:0] FLAG_BIT  = 8'h80;
	localparam logic [BYTE_W-1:0] LOW7_MASK = 8'h7f;

	typedef struct packed {
		logic [WORD_W-1:0] write_address;
		logic [BYTE_W-1:0] write_value;
		logic [LEN_W-1:0]  run_length;
	} wr_cmd_t;

	typedef struct packed {
		logic    gen;
		wr_cmd_t cmd;
	} parse_out_t;

endpackage

@@ sv/srle_if.sv @@
interface srle_in_if;
	logic                          valid;
	logic                          ready;
	logic [srle_pkg::BYTE_W-1:0]   stream_byte;
	logic                          image_start;

	modport source (output valid, stream_byte, image_start, input ready);
	modport sink (input valid, stream_byte, image_start, output ready);
endinterface

interface srle_out_if;
	logic                          valid;
	logic                          ready;
	logic [srle_pkg::WORD_W-1:0]   write_address;
	logic [srle_pkg::BYTE_W-1:0]   write_value;
	logic [srle_pkg::LEN_W-1:0]    run_length;

	modport source (output valid, write_address, write_value, run_length, input ready);
	modport sink (input valid, write_address, write_value, run_length, output ready);
endinterface

@@ sv/srle_parse.sv @@
`include "sparse_rle_memory_image_decoder_unit_defines.svh"

module srle_parse (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [srle_pkg::BYTE_W-1:0] data_b,
	input  logic                        start,
	output srle_pkg::parse_out_t        po
);

	typedef enum logic [1:0] {
		PH_OFFSET = 2'd0,
		PH_COUNT  = 2'd1,
		PH_DATA   = 2'd2
	} phase_t;

	phase_t                        phase_q, ph, ph_n;
	logic [srle_pkg::ADDR_W-1:0]   addr_q, a, a_n;
	logic [srle_pkg::LEN_W-1:0]    rem_q, r, r_n, len;
	logic                          fill_q, f, f_n;

	always_comb begin
		// start flag: parse this byte from the reset state
		ph = start ? PH_OFFSET : phase_q;
		a  = start ? '0 : addr_q;
		r  = start ? '0 : rem_q;
		f  = start ? 1'b0 : fill_q;

		len = f ? r : srle_pkg::LEN_W'(1);
		if (len == '0) begin
			len = srle_pkg::LEN_W'(1);
		end

		ph_n = ph;
		a_n  = a;
		r_n  = r;
		f_n  = f;
		po.gen = 1'b0;
		po.cmd.write_address = srle_pkg::WORD_W'(a);
		po.cmd.write_value   = data_b;
		po.cmd.run_length    = len;

		unique case (ph)
			PH_COUNT: begin
				r_n  = (data_b & srle_pkg::LOW7_MASK) + srle_pkg::LEN_W'(1);
				f_n  = (data_b & srle_pkg::FLAG_BIT) != '0;
				ph_n = PH_DATA;
			end
			PH_DATA: begin
				po.gen = 1'b1;
				a_n = a + srle_pkg::ADDR_W'(len);
				if (f || r <= srle_pkg::LEN_W'(1)) begin
					r_n  = '0;
					f_n  = 1'b0;
					ph_n = PH_OFFSET;
				end else begin
					r_n = r - srle_pkg::LEN_W'(1);
				end
			end
			default: begin
				// offset byte; also recovers from the unused phase code
				a_n = a + srle_pkg::ADDR_W'(data_b & srle_pkg::LOW7_MASK);
				f_n = 1'b0;
				if ((data_b & srle_pkg::FLAG_BIT) != '0) begin
					r_n  = '0;
					ph_n = PH_COUNT;
				end else begin
					r_n  = srle_pkg::LEN_W'(1);
					ph_n = PH_DATA;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OFFSET;
			addr_q  <= '0;
			rem_q   <= '0;
			fill_q  <= 1'b0;
		end else if (take) begin
			phase_q <= ph_n;
			addr_q  <= a_n;
			rem_q   <= r_n;
			fill_q  <= f_n;
		end
	end

	`SRLE_ASSERT_SAME(a_data_has_rem, phase_q == PH_DATA, rem_q != '0)
	`SRLE_ASSERT_SAME(a_fill_only_data, fill_q, phase_q == PH_DATA)
	`SRLE_ASSERT_NEXT(a_fill_ends_record,
		take && !start && phase_q == PH_DATA && fill_q, phase_q == PH_OFFSET)
	`SRLE_ASSERT_SAME(a_len_range, po.gen,
		po.cmd.run_length != '0 && po.cmd.run_length <= srle_pkg::LEN_W'(128))

endmodule

@@ sv/srle_out_reg.sv @@
module srle_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  srle_pkg::wr_cmd_t    cmd_in,
	output logic                 free,
	srle_out_if.source           cmd
);

	logic              valid_q;
	srle_pkg::wr_cmd_t cmd_q;

	assign free = !valid_q || cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (cmd.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= cmd_in;
		end
	end

	assign cmd.valid         = valid_q;
	assign cmd.write_address = cmd_q.write_address;
	assign cmd.write_value   = cmd_q.write_value;
	assign cmd.run_length    = cmd_q.run_length;

endmodule

@@ sv/sparse_rle_memory_image_decoder_unit.sv @@
// channel  dir  payload                                     handshake
// stream   in   stream_byte[7:0], image_start               valid/ready
// cmd      out  write_address[15:0], write_value[7:0],      valid/ready
//               run_length[7:0]
//
// One byte per cycle unless a cmd stall holds one; cmd valid is driven by the command register.
// Path: input register, parser state update, command register.
// Reset clears parser state and address; no clearing pass.
// A cmd stall holds the command register; bytes that make no command keep flowing,
// and a byte that makes one waits in the input register until the slot frees.
module sparse_rle_memory_image_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	srle_in_if.sink     stream,
	srle_out_if.source  cmd
);

	logic                        valid_s1;
	logic [srle_pkg::BYTE_W-1:0] byte_s1;
	logic                        start_s1;
	logic                        adv;
	logic                        out_free;
	srle_pkg::parse_out_t        po;

	assign adv          = valid_s1 && (!po.gen || out_free);
	assign stream.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1  <= stream.stream_byte;
			start_s1 <= stream.image_start;
		end
	end

	srle_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (adv),
		.data_b (byte_s1),
		.start  (start_s1),
		.po     (po)
	);

	srle_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv && po.gen),
		.cmd_in (po.cmd),
		.free   (out_free),
		.cmd    (cmd)
	);

endmodule
